// File: src/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked every clock outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: src/apo_pkg.sv
`timescale 1ns / 1ps
package apo_pkg;

  localparam int ALPHA_ROM_DEPTH_DEF = 4096;
  localparam int DATA_WIDTH_DEF      = 32;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_SETCMD = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [1:0] HOW_HELD   = 2'd0;
  localparam logic [1:0] HOW_REINIT = 2'd1;
  localparam logic [1:0] HOW_FILT   = 2'd2;

  localparam logic [1:0] REG_TAU_X   = 2'd0;
  localparam logic [1:0] REG_TAU_Y   = 2'd1;
  localparam logic [1:0] REG_MAX_GAP = 2'd2;

  localparam logic [31:0] MAX_GAP_RESET = 32'd250000000;

  typedef struct packed {
    logic [1:0]         func;
    logic [62:0]        stamp;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
    logic signed [31:0] cmd_x;
    logic signed [31:0] cmd_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_z;
    logic [1:0]         how_made;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic decide;    // classify update
    logic div_start; // start index division for the current axis
    logic div_step;  // one quotient bit
    logic rom_rd;    // alpha lookup
    logic mul1;      // prediction products
    logic mul2;      // prediction sum
    logic mul3;      // correction product
    logic wr_axis;   // store the axis result
    logic axis;      // 0 X, 1 Y
    logic commit;    // write state for the classified update
    logic setcmd;
    logic clear;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic [1:0] how;
    logic       div_done;
    logic       tau_zero;
  } dp_sts_t;

  // unsigned long division, shift and subtract
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f/256) in Q30, series through the 16th-order term with truncated terms
  function automatic logic [63:0] exp_q30(input int unsigned f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = udiv64(term * 64'(f), 64'd256 * 64'(n));
      if ((n & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum[63]) sum = '0;
    return sum;
  endfunction

  // ROM entry, used to fill the alpha table in the datapath
  function automatic logic [15:0] alpha_entry(input int unsigned idx);
    logic [63:0] v;
    logic [63:0] e1;
    logic [63:0] r;
    v  = exp_q30(idx & 32'd255);
    e1 = exp_q30(256);
    for (int k = int'(idx >> 8); k > 0; k--) begin
      if (v != 0) v = (v * e1 + (64'd1 << 29)) >> 30;
    end
    r = (v + 64'd8192) >> 14;
    if (r > 64'd65535) r = 64'd65535;
    return r[15:0];
  endfunction

endpackage

// File: src/apo_ctrl.sv
`timescale 1ns / 1ps
module apo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  apo_pkg::dp_sts_t  sts,
  output apo_pkg::dp_cmd_t  cmd
);
  import apo_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_DIVGO  = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_ROM    = 4'd4;
  localparam logic [3:0] S_MUL1   = 4'd5;
  localparam logic [3:0] S_MUL2   = 4'd6;
  localparam logic [3:0] S_MUL3   = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_COMMIT = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       axis;
  logic       axis_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // sequencing
  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.func == FUNC_SETCMD) begin
          cmd.setcmd = 1'b1;
          state_next = S_IDLE;
        end else if (sts.func == FUNC_CLEAR) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else if (sts.func == FUNC_UPDATE) begin
          cmd.decide = 1'b1;
          axis_next  = 1'b0;
          state_next = S_DIVGO;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIVGO: begin
        if (sts.how != HOW_FILT) begin
          state_next = S_COMMIT;
        end else if (sts.tau_zero) begin
          state_next = S_WR;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_ROM;
      end
      S_ROM: begin
        cmd.rom_rd = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_axis = 1'b1;
        if (axis) begin
          state_next = S_COMMIT;
        end else begin
          axis_next  = 1'b1;
          state_next = S_DIVGO;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/apo_dp.sv
`timescale 1ns / 1ps
module apo_dp #(
  parameter int ALPHA_ROM_DEPTH = apo_pkg::ALPHA_ROM_DEPTH_DEF,
  parameter int DATA_WIDTH      = apo_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  apo_pkg::in_item_t  in_item,
  input  logic [23:0]        tau_x_us,
  input  logic [23:0]        tau_y_us,
  input  logic [31:0]        max_gap_ns,
  input  apo_pkg::dp_cmd_t   cmd,
  output apo_pkg::dp_sts_t   sts,
  output apo_pkg::out_item_t out_item
);
  import apo_pkg::*;

  localparam int AW = $clog2(ALPHA_ROM_DEPTH);
  // dividend is dt<<8, 71 bits; divisor tau*1000 fits 34 bits
  localparam int NW = 71;
  localparam int DW = 34;
  localparam int CW = $clog2(NW + 1);
  localparam int PW = DATA_WIDTH + 18;
  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // alpha table
  logic [15:0] alpha_rom [ALPHA_ROM_DEPTH];
  always_comb begin
    for (int i = 0; i < ALPHA_ROM_DEPTH; i++) alpha_rom[i] = alpha_entry(i);
  end

  in_item_t item;
  logic signed [DATA_WIDTH-1:0] est [3];
  logic signed [DATA_WIDTH-1:0] lcmd [2];
  logic signed [DATA_WIDTH-1:0] newe [2];
  logic [62:0] last_stamp;
  logic        primed;
  logic [1:0]  how;
  logic [63:0] dt;

  // divider
  logic [NW-1:0] quo;
  logic [DW:0]   rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [16:0]   alpha;
  logic [16:0]   beta;
  logic signed [PW-1:0] pa, pb, pred, diff, corr;

  function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [PW:0] v);
    if (v > (PW+1)'(DMAX)) return DMAX;
    if (v < (PW+1)'(DMIN)) return DMIN;
    return v[DATA_WIDTH-1:0];
  endfunction

  logic signed [DATA_WIDTH-1:0] mx;
  logic signed [DATA_WIDTH-1:0] my;
  logic signed [DATA_WIDTH-1:0] mz;
  logic [23:0] tau_sel;
  assign mx = sat((PW+1)'(item.meas_x));
  assign my = sat((PW+1)'(item.meas_y));
  assign mz = sat((PW+1)'(item.meas_z));
  assign tau_sel = cmd.axis ? tau_y_us : tau_x_us;
  assign trial = {rem[DW-1:0], quo[NW-1]} - {1'b0, dvs};

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      primed     <= 1'b0;
      last_stamp <= '0;
      for (int i = 0; i < 3; i++) est[i] <= '0;
      for (int i = 0; i < 2; i++) lcmd[i] <= '0;
    end else begin
      if (cmd.load) item <= in_item;
      if (cmd.setcmd) begin
        lcmd[0] <= DATA_WIDTH'(item.cmd_x);
        lcmd[1] <= DATA_WIDTH'(item.cmd_y);
      end
      if (cmd.clear) begin
        primed     <= 1'b0;
        last_stamp <= '0;
        for (int i = 0; i < 3; i++) est[i] <= '0;
        for (int i = 0; i < 2; i++) lcmd[i] <= '0;
      end
      if (cmd.decide) begin
        dt <= {1'b0, item.stamp} - {1'b0, last_stamp};
        if (primed && item.stamp == last_stamp) how <= HOW_HELD;
        else if (!primed || item.stamp < last_stamp ||
                 (item.stamp - last_stamp) > {31'd0, max_gap_ns}) how <= HOW_REINIT;
        else how <= HOW_FILT;
      end
      if (cmd.div_start) begin
        quo <= {dt[62:0], 8'd0};
        rem <= '0;
        dvs <= DW'(tau_sel) * DW'(1000);
        cnt <= '0;
      end
      if (cmd.div_step) begin
        if (!trial[DW]) begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-1:0], quo[NW-1]};
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      if (cmd.rom_rd) begin
        if (quo >= NW'(ALPHA_ROM_DEPTH)) alpha <= '0;
        else alpha <= {1'b0, alpha_rom[quo[AW-1:0]]};
      end
      if (cmd.mul1) begin
        beta <= 17'd65536 - alpha;
        pa   <= PW'($signed({1'b0, alpha})) * PW'(est[cmd.axis]);
        pb   <= PW'($signed({1'b0, 17'd65536 - alpha})) * PW'(lcmd[cmd.axis]);
      end
      if (cmd.mul2) begin
        pred <= (pa + pb) >>> 16;
        diff <= PW'(cmd.axis ? my : mx) - ((pa + pb) >>> 16);
      end
      if (cmd.mul3) corr <= (PW'($signed({1'b0, beta})) * diff) >>> 16;
      if (cmd.wr_axis) begin
        if (tau_sel == '0) newe[cmd.axis] <= cmd.axis ? my : mx;
        else newe[cmd.axis] <= sat({pred[PW-1], pred} + {corr[PW-1], corr});
      end
      if (cmd.commit) begin
        if (how == HOW_REINIT) begin
          est[0] <= mx; est[1] <= my; est[2] <= mz;
          last_stamp <= item.stamp;
          primed <= 1'b1;
        end else if (how == HOW_FILT) begin
          est[0] <= newe[0]; est[1] <= newe[1]; est[2] <= mz;
          last_stamp <= item.stamp;
        end
      end
    end
  end

  assign sts.func     = item.func;
  assign sts.how      = how;
  assign sts.div_done = (cnt == CW'(NW - 1)) && cmd.div_step;
  assign sts.tau_zero = (tau_sel == '0);

  assign out_item.est_x    = 32'(est[0]);
  assign out_item.est_y    = 32'(est[1]);
  assign out_item.est_z    = 32'(est[2]);
  assign out_item.how_made = how;

endmodule

// File: src/accel_prediction_observer.sv
`timescale 1ns / 1ps
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | in_data  (apo_pkg::in_item_t)
// output  | out_valid | out_stall | out_data (apo_pkg::out_item_t)
// Set command, clear and unused func: decoded and applied with no result; the input then reopens.
// Held or reloaded update: decode and classify, commit, then the result is valid at the output.
// Filtered update, per axis with nonzero tau: 71-step radix-2 index divider, alpha lookup,
// three multiply steps and write; a pass-through axis (zero tau) is only written; then commit
// and result. Output stalls hold the result until it is taken.
// One transaction in flight; input stalls until it completes and any result is taken.
// Reset is synchronous; it clears state and loads register defaults.
module accel_prediction_observer #(
  parameter int ALPHA_ROM_DEPTH = apo_pkg::ALPHA_ROM_DEPTH_DEF,
  parameter int DATA_WIDTH      = apo_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  apo_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output apo_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import apo_pkg::*;

  logic [23:0] tau_x_us;
  logic [23:0] tau_y_us;
  logic [31:0] max_gap_ns;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      tau_x_us   <= '0;
      tau_y_us   <= '0;
      max_gap_ns <= MAX_GAP_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[3:2] == REG_TAU_X) tau_x_us <= pwdata[23:0];
      else if (paddr[3:2] == REG_TAU_Y) tau_y_us <= pwdata[23:0];
      else if (paddr[3:2] == REG_MAX_GAP) max_gap_ns <= pwdata;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TAU_X:   prdata = {8'd0, tau_x_us};
      REG_TAU_Y:   prdata = {8'd0, tau_y_us};
      REG_MAX_GAP: prdata = max_gap_ns;
      default:     prdata = '0;
    endcase
  end

  apo_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  apo_dp #(.ALPHA_ROM_DEPTH(ALPHA_ROM_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst, .in_item(in_data), .tau_x_us, .tau_y_us, .max_gap_ns,
    .cmd, .sts, .out_item(out_data)
  );

endmodule

// File: src/apo_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module apo_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] how_made
);
  import apo_pkg::*;

  `ASSERT_IMPL(a_busy_out, clk, rst, out_valid, in_stall, "input open while result pending")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  `ASSERT_IMPL(a_how, clk, rst, out_valid, how_made <= HOW_FILT, "bad how_made")
  `ASSERT_NEXT(a_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted while busy")
endmodule

bind accel_prediction_observer apo_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .how_made(out_data.how_made)
);

// File: test/tb_accel_prediction_observer.sv
`timescale 1ns / 1ps
module tb_accel_prediction_observer;
  import apo_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  accel_prediction_observer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // observer copy used for prediction
  logic [23:0] m_tau_x, m_tau_y;
  logic [31:0] m_max_gap;
  longint m_est [3];
  longint m_cmd [2];
  logic [63:0] m_stamp;
  bit m_primed;
  logic [15:0] alpha_tab [4096];

  out_item_t est_queue [$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [63:0] t_now;

  // Q30 series for exp(-f/256)
  function automatic longint series_q30(int unsigned f);
    longint s;
    longint unsigned t;
    s = 64'sd1 << 30;
    t = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      t = (t * f) / (256 * n);
      if (n % 2) s -= longint'(t);
      else s += longint'(t);
    end
    return s < 0 ? 0 : s;
  endfunction

  task automatic build_alpha();
    longint unsigned v, e1, r;
    e1 = series_q30(256);
    for (int i = 0; i < 4096; i++) begin
      v = series_q30(i % 256);
      for (int k = i / 256; k > 0 && v != 0; k--) v = (v * e1 + (64'd1 << 29)) >> 30;
      r = (v + 8192) >> 14;
      if (r > 65535) r = 65535;
      alpha_tab[i] = r[15:0];
    end
  endtask

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor16(longint x);
    return x >>> 16;
  endfunction

  function automatic void clear_model();
    foreach (m_est[i]) m_est[i] = 0;
    m_cmd[0] = 0;
    m_cmd[1] = 0;
    m_stamp = 0;
    m_primed = 0;
  endfunction

  // predict the observer's reaction to one item
  function automatic void predict_observer(in_item_t it);
    out_item_t r;
    logic [63:0] st, dt, idx;
    longint meas [3];
    longint a, b, pred;
    logic [23:0] tau;
    logic [1:0] how;
    if (it.func == FUNC_SETCMD) begin
      m_cmd[0] = longint'(it.cmd_x);
      m_cmd[1] = longint'(it.cmd_y);
      return;
    end
    if (it.func == FUNC_CLEAR) begin
      clear_model();
      return;
    end
    if (it.func != FUNC_UPDATE) return;
    st = {1'b0, it.stamp};
    meas[0] = longint'(it.meas_x);
    meas[1] = longint'(it.meas_y);
    meas[2] = longint'(it.meas_z);
    if (m_primed && st == m_stamp) begin
      how = HOW_HELD;
    end else if (!m_primed || st < m_stamp || st - m_stamp > {32'd0, m_max_gap}) begin
      for (int k = 0; k < 3; k++) m_est[k] = meas[k];
      m_stamp = st;
      m_primed = 1;
      how = HOW_REINIT;
    end else begin
      dt = st - m_stamp;
      for (int k = 0; k < 2; k++) begin
        tau = k == 0 ? m_tau_x : m_tau_y;
        if (tau == 0) begin
          m_est[k] = meas[k];
        end else begin
          idx = (dt << 8) / (64'(tau) * 64'd1000);
          a = idx < 4096 ? longint'(alpha_tab[idx[11:0]]) : 0;
          b = 65536 - a;
          pred = floor16(a * m_est[k] + b * m_cmd[k]);
          m_est[k] = sat32(pred + floor16(b * (meas[k] - pred)));
        end
      end
      m_est[2] = meas[2];
      m_stamp = st;
      how = HOW_FILT;
    end
    r.est_x = m_est[0][31:0];
    r.est_y = m_est[1][31:0];
    r.est_z = m_est[2][31:0];
    r.how_made = how;
    est_queue = {est_queue, r};
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (est_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        e = est_queue.pop_front();
        if (out_data.est_x !== e.est_x || out_data.est_y !== e.est_y ||
            out_data.est_z !== e.est_z || out_data.how_made !== e.how_made) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %0d, got %h %h %h %0d",
                     e.est_x, e.est_y, e.est_z, e.how_made, out_data.est_x,
                     out_data.est_y, out_data.est_z, out_data.how_made);
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one transaction on the input channel
  task automatic send_item(in_item_t it);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_observer(it);
    items_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TAU_X: m_tau_x = val[23:0];
      REG_TAU_Y: m_tau_y = val[23:0];
      REG_MAX_GAP: m_max_gap = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (est_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  function automatic in_item_t make_update(logic [62:0] st);
    in_item_t it;
    it = '0;
    it.func = FUNC_UPDATE;
    it.stamp = st;
    it.meas_x = $urandom;
    it.meas_y = $urandom;
    it.meas_z = $urandom;
    it.cmd_x = $urandom;
    it.cmd_y = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_setcmd();
    in_item_t it;
    it = make_update(63'({$urandom, $urandom}));
    it.func = FUNC_SETCMD;
    return it;
  endfunction

  // extremes, every function, each special case
  task automatic test_directed();
    in_item_t it;
    it = make_update(63'd1000);
    it.meas_x = 32'sh7fffffff;
    it.meas_y = 32'sh80000000;
    send_item(it);
    send_item(make_update(63'd1000));
    send_item(make_update(63'd500));
    send_item(make_update(63'd5000));
    it = make_setcmd();
    it.cmd_x = 32'sh7fffffff;
    it.cmd_y = 32'sh80000000;
    send_item(it);
    send_item(make_update(63'd9000));
    it = make_update(63'd0);
    it.func = FUNC_RSVD;
    send_item(it);
    it.func = FUNC_CLEAR;
    send_item(it);
    send_item(make_update(63'h7fffffffffffffff));
    send_item(make_update(63'h7fffffffffffffff));
    wait_idle();
    reg_write(REG_TAU_X, 32'hffffffff);
    reg_write(REG_TAU_Y, 32'd1);
    reg_write(REG_MAX_GAP, 32'hffffffff);
    send_item(make_update(63'd0));
    send_item(make_update(63'd1));
    send_item(make_update(63'd1 + 63'd3));
    send_item(make_update(63'd16000001));
    send_item(make_update(63'd4294967296 + 63'd16000001));
    wait_idle();
    reg_write(REG_MAX_GAP, 32'd0);
    send_item(make_update(63'd100));
    send_item(make_update(63'd100));
    send_item(make_update(63'd101));
    wait_idle();
  endtask

  // random sequences, mostly rising stamps with small gaps
  task automatic test_random(int n);
    in_item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_item(make_setcmd());
      end else if (r < 10) begin
        it = make_setcmd();
        it.func = $urandom_range(1) ? FUNC_CLEAR : FUNC_RSVD;
        send_item(it);
      end else begin
        r = $urandom_range(99);
        if (r < 70) t_now += $urandom_range(20000000);
        else if (r < 78) t_now += 0;
        else if (r < 84) t_now -= $urandom_range(1000);
        else if (r < 92) t_now += {$urandom_range(3), $urandom};
        else t_now = {$urandom, $urandom};
        t_now[63] = 1'b0;
        send_item(make_update(t_now[62:0]));
      end
    end
    wait_idle();
  endtask

  task automatic test_settings();
    reg_write(REG_TAU_X, 32'd20000);
    reg_write(REG_TAU_Y, 32'd3000);
    reg_write(REG_MAX_GAP, MAX_GAP_RESET);
    send_idle_pct = 11;
    recv_idle_pct = 64;
    test_random(230);
    reg_write(REG_TAU_X, 32'd0);
    reg_write(REG_TAU_Y, 32'd10000000);
    reg_write(REG_MAX_GAP, 32'd1);
    send_idle_pct = 64;
    recv_idle_pct = 11;
    test_random(40);
    reg_write(REG_TAU_X, 32'd500);
    reg_write(REG_TAU_Y, 32'd0);
    reg_write(REG_MAX_GAP, 32'd4000000000);
    test_random(190);
    reg_write(REG_TAU_X, $urandom_range(1, 50000));
    reg_write(REG_TAU_Y, $urandom_range(1, 50000));
    reg_write(REG_MAX_GAP, 32'd60000000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(220);
  endtask

  // sequence
  initial begin
    build_alpha();
    clear_model();
    m_tau_x = 0;
    m_tau_y = 0;
    m_max_gap = MAX_GAP_RESET;
    t_now = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_settings();
    $display("Sent %0d items, checked %0d results over several tau and gap settings.",
             items_sent, results_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && est_queue.size() == 0) begin
      $display("tb_accel_prediction_observer: PASS");
    end else begin
      $display("tb_accel_prediction_observer: FAIL");
    end
    $finish;
  end

  // timeout
  initial begin
    #400ms;
    $display("tb_accel_prediction_observer: FAIL");
    $finish;
  end

endmodule
